FILE: rtl/core/urbf_pkg.sv
package urbf_pkg;

    localparam int PULSE_W = 16;
    localparam int SUM_W   = 21;
    localparam int SQ_W    = 37;
    localparam int LIMIT_W = 32;
    localparam int MEAN_W  = 17;
    localparam int STATUS_W = 2;

    localparam int READINGS_PER_BATCH_DEFAULT = 20;

    localparam logic [LIMIT_W-1:0] VARIANCE_LIMIT_RESET = 32'd306;

    // mean distance = sum * MEAN_MUL / (MEAN_DIV * N), hundredths of cm
    localparam int MEAN_MUL = 1715;
    localparam int MEAN_DIV = 1000;

    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SPREAD   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd2;

    typedef logic [PULSE_W-1:0]  pulse_t;
    typedef logic [MEAN_W-1:0]   mean_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [LIMIT_W-1:0]  limit_t;

endpackage

FILE: rtl/core/urbf_ifs.sv
interface urbf_reading_if;
    import urbf_pkg::*;

    logic   valid;
    logic   ready;
    pulse_t pulse_us;
    logic   timed_out;

    modport source (output valid, output pulse_us, output timed_out, input ready);
    modport sink   (input valid, input pulse_us, input timed_out, output ready);
endinterface

interface urbf_result_if;
    import urbf_pkg::*;

    logic    valid;
    logic    ready;
    mean_t   mean_distance;
    status_t status;

    modport source (output valid, output mean_distance, output status, input ready);
    modport sink   (input valid, input mean_distance, input status, output ready);
endinterface

interface urbf_cfg_if;
    import urbf_pkg::*;

    logic   valid;
    logic   ready;
    limit_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ultrasonic_range_batch_filter_top.sv
// channel   dir   payload                          request
// reading   in    pulse_us[15:0], timed_out        one echo reading
// result    out   mean_distance[16:0], status[1:0] one per batch of N readings
// cfg       in    data[31:0]                       variance_limit write
//
// Takes one reading per cycle while reading.ready is high; accumulation is a combinational
// multiply-add. A batch result passes from its last accepted reading through a pipeline
// (square/scale, spread compare, remainder, mean fix-up) to the result register.
// Reset clears the batch state and sets variance_limit to 306.
// Stages hold under a stalled result and bubbles collapse, so readings keep
// flowing while a result waits, until the pipeline is full.
module ultrasonic_range_batch_filter_top #(
    parameter int READINGS_PER_BATCH = urbf_pkg::READINGS_PER_BATCH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    urbf_reading_if.sink  reading,
    urbf_result_if.source result,
    urbf_cfg_if.sink      cfg
);
    import urbf_pkg::*;

    localparam int CNT_W   = $clog2(READINGS_PER_BATCH + 1);
    localparam int NSQ_W   = SQ_W + CNT_W;
    localparam int SQR_W   = 2 * SUM_W;
    localparam int BND_W   = LIMIT_W + 2 * CNT_W;
    localparam int TMP_W   = (NSQ_W > SQR_W) ? NSQ_W : SQR_W;
    localparam int CMP_W   = (TMP_W > BND_W) ? TMP_W : BND_W;
    localparam int NN      = READINGS_PER_BATCH * READINGS_PER_BATCH;
    localparam int DIVISOR = MEAN_DIV * READINGS_PER_BATCH;
    localparam longint unsigned RECIP = (longint'(MEAN_MUL) << SUM_W) / DIVISOR;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int X_W     = SUM_W + $clog2(MEAN_MUL + 1);
    localparam int D_W     = $clog2(DIVISOR + 1);
    localparam int REM_W   = D_W + 1;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sqsum_reg;
    logic             inv_reg;
    logic [CMP_W-1:0] bound_reg;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic             en1, en2, en3, en4, en_out;

    logic [SUM_W-1:0] s1_sum_reg;
    logic [SQ_W-1:0]  s1_sq_reg;
    logic             s1_inv_reg;

    logic [CMP_W-1:0]  s2_nsq_reg, s2_sqr_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [X_W-1:0]    s2_x_reg;
    logic              s2_inv_reg;

    logic [RECIP_W-1:0] s3_est_reg;
    logic [X_W-1:0]     s3_x_reg;
    status_t            s3_status_reg;

    logic [RECIP_W-1:0] s4_est_reg;
    logic [REM_W-1:0]   s4_rem_reg;
    status_t            s4_status_reg;

    mean_t              out_mean_reg;
    status_t            out_status_reg;

    logic             accept, last;
    logic [SUM_W-1:0] add_w;
    logic [SQ_W-1:0]  add_sq;
    logic [SUM_W-1:0] sum_next;
    logic [SQ_W-1:0]  sqsum_next;
    logic             inv_next;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] spread;
    status_t          status_next;
    logic [X_W-1:0]   rem_full;
    logic [RECIP_W:0] mean_full;
    mean_t            mean_next;

    assign en_out = !out_valid_reg || result.ready;
    assign en4    = !s4_valid_reg || en_out;
    assign en3    = !s3_valid_reg || en4;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    assign reading.ready = en1;
    assign cfg.ready     = 1'b1;
    assign accept        = reading.valid && en1;

    assign add_w      = reading.timed_out ? '0 : SUM_W'(reading.pulse_us);
    assign add_sq     = reading.timed_out ? '0 :
                        SQ_W'(reading.pulse_us) * SQ_W'(reading.pulse_us);
    assign sum_next   = sum_reg + add_w;
    assign sqsum_next = sqsum_reg + add_sq;
    assign inv_next   = inv_reg || reading.timed_out;
    assign count_next = count_reg + 1'b1;
    assign last       = (count_next == CNT_W'(READINGS_PER_BATCH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            inv_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sqsum_reg <= '0;
                inv_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sqsum_reg <= sqsum_next;
                inv_reg   <= inv_next;
            end
        end
    end

    // limit is kept pre-scaled by N^2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bound_reg <= CMP_W'(VARIANCE_LIMIT_RESET) * CMP_W'(NN);
        else if (cfg.valid)
            bound_reg <= CMP_W'(cfg.data) * CMP_W'(NN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= accept && last;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
            if (en_out)
                out_valid_reg <= s4_valid_reg;
        end
    end

    assign spread = (s2_nsq_reg >= s2_sqr_reg) ? (s2_nsq_reg - s2_sqr_reg) : '0;

    always_comb
    begin
        if (s2_inv_reg)
            status_next = STATUS_TIMEOUT;
        else if (spread < bound_reg)
            status_next = STATUS_ACCEPTED;
        else
            status_next = STATUS_SPREAD;
    end

    // estimate is exact or one low; remainder below 2*DIVISOR
    assign rem_full  = s3_x_reg - X_W'(s3_est_reg) * X_W'(DIVISOR);
    assign mean_full = (s4_rem_reg >= REM_W'(DIVISOR)) ?
                       ((RECIP_W+1)'(s4_est_reg) + 1'b1) : (RECIP_W+1)'(s4_est_reg);
    assign mean_next = (s4_status_reg == STATUS_TIMEOUT) ? '0 : mean_full[MEAN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en1 && accept && last)
        begin
            s1_sum_reg <= sum_next;
            s1_sq_reg  <= sqsum_next;
            s1_inv_reg <= inv_next;
        end
        if (en2)
        begin
            s2_nsq_reg  <= CMP_W'(s1_sq_reg) * CMP_W'(READINGS_PER_BATCH);
            s2_sqr_reg  <= CMP_W'(s1_sum_reg) * CMP_W'(s1_sum_reg);
            s2_prod_reg <= PROD_W'(s1_sum_reg) * PROD_W'(RECIP);
            s2_x_reg    <= X_W'(s1_sum_reg) * X_W'(MEAN_MUL);
            s2_inv_reg  <= s1_inv_reg;
        end
        if (en3)
        begin
            s3_est_reg    <= s2_prod_reg[SUM_W +: RECIP_W];
            s3_x_reg      <= s2_x_reg;
            s3_status_reg <= status_next;
        end
        if (en4)
        begin
            s4_est_reg    <= s3_est_reg;
            s4_rem_reg    <= rem_full[REM_W-1:0];
            s4_status_reg <= s3_status_reg;
        end
        if (en_out)
        begin
            out_mean_reg   <= mean_next;
            out_status_reg <= s4_status_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.mean_distance = out_mean_reg;
    assign result.status        = out_status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(READINGS_PER_BATCH))
        else $error("batch count out of range");

    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg == CNT_W'(READINGS_PER_BATCH - 1)) |=> s1_valid_reg)
        else $error("batch end not captured");

    a_timeout_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_TIMEOUT) |-> result.mean_distance == '0)
        else $error("timeout batch carries a mean");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == STATUS_ACCEPTED || result.status == STATUS_SPREAD
                          || result.status == STATUS_TIMEOUT))
        else $error("bad status code");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_rem_reg < REM_W'(2 * DIVISOR))
        else $error("mean remainder out of range");

endmodule
